[design/integer_to_radix_digits_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for integer_to_radix_digits
// Shared property wrappers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_DIGITS_DEFINES_SVH
`define INTEGER_TO_RADIX_DIGITS_DEFINES_SVH

// Same-cycle implication.
`define ITRD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ITRD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/itrd_pkg.sv]
// ----------------------------------------------------------------------------
// itrd_pkg
// Types and constants shared by the radix conversion controller and datapath.
// ----------------------------------------------------------------------------
package itrd_pkg;

	localparam int MAX_RADIX   = 16;
	localparam int ALPHA_SLOTS = 16;
	localparam int RADIX_W     = 5;
	localparam int DIGIT_W     = 4;
	localparam int CHAR_W      = 8;
	localparam int CFG_W       = 64;
	localparam int CFG_IDX_W   = 2;
	localparam int ALPHA_W     = 2 * CFG_W;
	localparam int STEP_BITS   = 8;

	localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0]  CHAR_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0]  CHAR_NUL   = 8'h00;

	localparam logic [RADIX_W-1:0] RADIX_RESET      = 5'd10;
	localparam logic [CFG_W-1:0]   ALPHA_LOW_RESET  = 64'h3736_3534_3332_3130;
	localparam logic [CFG_W-1:0]   ALPHA_HIGH_RESET = 64'h0000_0000_0000_3938;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIX      = 2'd0,
		REG_ALPHA_LOW  = 2'd1,
		REG_ALPHA_HIGH = 2'd2
	} cfg_reg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic div_step;
		logic put_sign;
		logic put_digit;
	} itrd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic neg;
		logic digit_end;
		logic last_digit;
		logic out_free;
	} itrd_stat_t;

endpackage

[design/itrd_cfg.sv]
// ----------------------------------------------------------------------------
// itrd_cfg
// Configuration registers and the registered alphabet validity check.
// ----------------------------------------------------------------------------
module itrd_cfg import itrd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic [RADIX_W-1:0]   radix,
	output logic [ALPHA_W-1:0]   alphabet,
	output logic                 alpha_ok
);

	logic [RADIX_W-1:0] radix_q;
	logic [CFG_W-1:0]   alpha_low_q;
	logic [CFG_W-1:0]   alpha_high_q;
	logic [CHAR_W-1:0]  chars [ALPHA_SLOTS];
	logic               used  [ALPHA_SLOTS];
	logic               ok;
	logic               alpha_ok_q;

	// Register file; writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q      <= RADIX_RESET;
			alpha_low_q  <= ALPHA_LOW_RESET;
			alpha_high_q <= ALPHA_HIGH_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_RADIX:      radix_q      <= cfg_data[RADIX_W-1:0];
				REG_ALPHA_LOW:  alpha_low_q  <= cfg_data;
				REG_ALPHA_HIGH: alpha_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign alphabet = {alpha_high_q, alpha_low_q};
	assign radix    = radix_q;

	// Slot characters and which of them the radix puts in use.
	always_comb begin
		for (int i = 0; i < ALPHA_SLOTS; i++) begin
			chars[i] = alphabet[i*CHAR_W +: CHAR_W];
			used[i]  = RADIX_W'(i) < radix_q;
		end
	end

	// Radix in range, no forbidden characters, no repeats among used slots.
	always_comb begin
		ok = (radix_q >= RADIX_W'(2)) && (radix_q <= RADIX_W'(MAX_RADIX))
			&& (radix_q <= RADIX_W'(ALPHA_SLOTS));
		for (int i = 0; i < ALPHA_SLOTS; i++) begin
			if (used[i] && (chars[i] == CHAR_NUL || chars[i] == CHAR_MINUS
					|| chars[i] == CHAR_PLUS))
				ok = 1'b0;
			for (int j = i + 1; j < ALPHA_SLOTS; j++) begin
				if (used[j] && chars[i] == chars[j])
					ok = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			alpha_ok_q <= 1'b1;
		else
			alpha_ok_q <= ok;
	end

	assign alpha_ok = alpha_ok_q;

endmodule

[design/itrd_datapath.sv]
// ----------------------------------------------------------------------------
// itrd_datapath
// Magnitude register, chunked long divider, digit store and output register.
// ----------------------------------------------------------------------------
module itrd_datapath import itrd_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  itrd_cmd_t                     cmd,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  logic [RADIX_W-1:0]            radix,
	input  logic [ALPHA_W-1:0]            alphabet,
	input  logic                          m_tready,
	output itrd_stat_t                    stat,
	output logic                          m_tvalid,
	output logic [CHAR_W-1:0]             m_tdata,
	output logic                          m_tlast
);

	localparam int CHUNKS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
	localparam int PAD_W  = CHUNKS * STEP_BITS;
	localparam int CH_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int IDX_W  = $clog2(VALUE_WIDTH);

	logic [VALUE_WIDTH-1:0] value_u;
	logic [VALUE_WIDTH-1:0] abs_val;
	logic [PAD_W-1:0]       mag_q;
	logic [PAD_W-1:0]       mag_next;
	logic                   neg_q;
	logic [DIGIT_W-1:0]     rem_q;
	logic [DIGIT_W-1:0]     div_rem;
	logic [RADIX_W-1:0]     trial;
	logic [STEP_BITS-1:0]   qbits;
	logic [CH_W-1:0]        chunk_q;
	logic                   chunk_last;
	logic                   full;
	logic                   quot_zero;
	logic                   digit_wr;
	logic [IDX_W-1:0]       wr_ptr_q;
	logic [IDX_W-1:0]       rd_ptr_q;
	logic [DIGIT_W-1:0]     store_q [VALUE_WIDTH];
	logic [DIGIT_W-1:0]     rd_data_q;
	logic [CHAR_W-1:0]      digit_char;
	logic                   out_valid_q;
	logic [CHAR_W-1:0]      char_q;
	logic                   last_q;

	// Two's complement magnitude; the most negative value maps to 2^(W-1).
	assign value_u = value;
	assign abs_val = value_u[VALUE_WIDTH-1] ? (~value_u + 1'b1) : value_u;

	// One chunk of restoring division: STEP_BITS quotient bits per cycle.
	always_comb begin
		div_rem = (chunk_q == '0) ? '0 : rem_q;
		trial   = '0;
		qbits   = '0;
		for (int b = STEP_BITS - 1; b >= 0; b--) begin
			trial = {div_rem, mag_q[PAD_W-STEP_BITS+b]};
			if (trial >= radix) begin
				div_rem  = DIGIT_W'(trial - radix);
				qbits[b] = 1'b1;
			end else begin
				div_rem  = trial[DIGIT_W-1:0];
			end
		end
	end

	assign mag_next   = PAD_W'({mag_q, qbits});
	assign quot_zero  = (mag_next == '0);
	assign chunk_last = (chunk_q == CH_W'(CHUNKS - 1));
	assign full       = (wr_ptr_q == IDX_W'(VALUE_WIDTH - 1));
	assign digit_wr   = cmd.div_step && chunk_last;

	// Dividend, partial remainder and sign.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= PAD_W'(abs_val);
			neg_q <= value_u[VALUE_WIDTH-1];
		end else if (cmd.div_step) begin
			mag_q <= mag_next;
			rem_q <= div_rem;
		end
	end

	// Chunk counter and store pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q  <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (cmd.load) begin
				chunk_q  <= '0;
				wr_ptr_q <= '0;
			end else if (cmd.div_step) begin
				chunk_q <= chunk_last ? '0 : chunk_q + 1'b1;
				if (chunk_last) begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
					rd_ptr_q <= wr_ptr_q;
				end
			end
			if (cmd.put_digit)
				rd_ptr_q <= rd_ptr_q - 1'b1;
		end
	end

	// Digit store, least significant digit at entry zero.
	always_ff @(posedge clk) begin
		if (digit_wr)
			store_q[wr_ptr_q] <= div_rem;
		rd_data_q <= store_q[rd_ptr_q];
	end

	assign digit_char = alphabet[{rd_data_q, 3'b000} +: CHAR_W];

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.put_sign || cmd.put_digit)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.put_sign) begin
			char_q <= CHAR_MINUS;
			last_q <= 1'b0;
		end else if (cmd.put_digit) begin
			char_q <= digit_char;
			last_q <= (rd_ptr_q == '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = char_q;
	assign m_tlast  = last_q;

	assign stat.neg        = neg_q;
	assign stat.digit_end  = digit_wr && (quot_zero || full);
	assign stat.last_digit = (rd_ptr_q == '0);
	assign stat.out_free   = !out_valid_q || m_tready;

endmodule

[design/itrd_ctrl.sv]
// ----------------------------------------------------------------------------
// itrd_ctrl
// Conversion sequencer: check, divide digit by digit, then emit characters.
// ----------------------------------------------------------------------------
`include "integer_to_radix_digits_defines.svh"

module itrd_ctrl import itrd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       alpha_ok,
	input  itrd_stat_t stat,
	output logic       s_tready,
	output itrd_cmd_t  cmd
);

	typedef enum logic [2:0] {
		IDLE,
		CHECK,
		DIV,
		SIGN,
		SEND,
		READ
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   accept;

	assign accept   = s_tvalid && ready_q;
	assign s_tready = ready_q;

	// Commands decoded from the current state.
	always_comb begin
		cmd      = '0;
		cmd.load = accept;
		unique case (state_q)
			DIV:     cmd.div_step  = 1'b1;
			SIGN:    cmd.put_sign  = stat.neg && stat.out_free;
			SEND:    cmd.put_digit = stat.out_free;
			default: ;
		endcase
	end

	// State and input ready.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						state_q <= CHECK;
						ready_q <= 1'b0;
					end
				end
				CHECK: begin
					if (alpha_ok) begin
						state_q <= DIV;
					end else begin
						state_q <= IDLE;
						ready_q <= 1'b1;
					end
				end
				DIV: begin
					if (stat.digit_end)
						state_q <= SIGN;
				end
				SIGN: begin
					if (!stat.neg || stat.out_free)
						state_q <= SEND;
				end
				SEND: begin
					if (stat.out_free) begin
						if (stat.last_digit) begin
							state_q <= IDLE;
							ready_q <= 1'b1;
						end else begin
							state_q <= READ;
						end
					end
				end
				READ: state_q <= SEND;
				default: begin
					state_q <= IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	`ITRD_ASSERT_IMPL(a_put_has_room, (cmd.put_sign || cmd.put_digit), stat.out_free, "word loaded over a pending word")
	`ITRD_ASSERT_NEXT(a_accept_starts, accept, (state_q == CHECK && !ready_q), "accepted word did not start a conversion")
	`ITRD_ASSERT_NEXT(a_bad_alpha_drops, (state_q == CHECK && !alpha_ok), (state_q == IDLE && ready_q), "invalid alphabet did not drop the word")
	`ITRD_ASSERT_IMPL(a_ready_in_idle, ready_q, (state_q == IDLE), "ready raised outside idle")

endmodule

[design/integer_to_radix_digits.sv]
// A value is accepted and the alphabet checked; the divider then works out one
// digit at a time in chunks (8 quotient bits per cycle), and the characters are
// then sent, each digit read from the store before it goes out. One conversion
// at a time; the SIGN state is visited for every value, so a minus sign needs no
// extra state. An invalid alphabet drops the value. Reset: radix 10, alphabet
// "0123456789", controller idle, no output pending; the digit store is not cleared.
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// Converts a signed integer to text in a configured radix, one character per
// output word, most significant digit first, after a minus sign if negative.
// ----------------------------------------------------------------------------
module integer_to_radix_digits import itrd_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write port.
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	// Input stream.
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [((VALUE_WIDTH+7)/8)*8-1:0] s_tdata,   // value
	// Output stream.
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [CHAR_W-1:0]    m_tdata,               // character
	output logic                 m_tlast
);

	logic [RADIX_W-1:0]            radix;
	logic [ALPHA_W-1:0]            alphabet;
	logic                          alpha_ok;
	logic signed [VALUE_WIDTH-1:0] value;
	itrd_cmd_t                     cmd;
	itrd_stat_t                    stat;

	assign value = signed'(s_tdata[VALUE_WIDTH-1:0]);

	itrd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.radix     (radix),
		.alphabet  (alphabet),
		.alpha_ok  (alpha_ok)
	);

	itrd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.alpha_ok (alpha_ok),
		.stat     (stat),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	itrd_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.value    (value),
		.radix    (radix),
		.alphabet (alphabet),
		.m_tready (m_tready),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
